// ===== src/spmd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spmd_pkg;

    localparam int SIGNAL_COUNT = 31;
    localparam int SIG_TOP      = (SIGNAL_COUNT > 31) ? 31 : SIGNAL_COUNT;

    localparam int SET_W = 32;
    localparam int SIG_W = 5;

    // signals 1..SIG_TOP
    localparam logic [SET_W-1:0] SIG_MASK =
        SET_W'(((64'd1 << (SIG_TOP + 1)) - 64'd2));

    localparam logic [SIG_W-1:0] SIG_HUP  = 5'd1;
    localparam logic [SIG_W-1:0] SIG_INT  = 5'd2;
    localparam logic [SIG_W-1:0] SIG_QUIT = 5'd3;
    localparam logic [SIG_W-1:0] SIG_ILL  = 5'd4;
    localparam logic [SIG_W-1:0] SIG_TRAP = 5'd5;
    localparam logic [SIG_W-1:0] SIG_ABRT = 5'd6;
    localparam logic [SIG_W-1:0] SIG_KILL = 5'd9;
    localparam logic [SIG_W-1:0] SIG_TERM = 5'd15;

    localparam logic [SET_W-1:0] TERM_DEFAULT_MASK =
        (SET_W'(1) << SIG_INT) | (SET_W'(1) << SIG_QUIT) | (SET_W'(1) << SIG_ILL) |
        (SET_W'(1) << SIG_ABRT) | (SET_W'(1) << SIG_TERM);
    localparam logic [SET_W-1:0] STOP_DEFAULT_MASK =
        (SET_W'(1) << SIG_HUP) | (SET_W'(1) << SIG_TRAP);
    localparam logic [SET_W-1:0] HANDLER_IGNORED =
        SET_W'(1) | (SET_W'(1) << SIG_KILL);

    localparam logic [2:0] OPC_SEND    = 3'd0;
    localparam logic [2:0] OPC_BLOCK   = 3'd1;
    localparam logic [2:0] OPC_UNBLOCK = 3'd2;
    localparam logic [2:0] OPC_DELIVER = 3'd3;
    localparam logic [2:0] OPC_QUERY   = 3'd4;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int CFG_AW = 3;

    typedef enum logic [2:0] {
        OP_SEND,
        OP_BLOCK,
        OP_UNBLOCK,
        OP_DELIVER,
        OP_QUERY,
        OP_OTHER
    } t_op;

    typedef enum logic [2:0] {
        ACT_NOTHING  = 3'd0,
        ACT_BASIC    = 3'd1,
        ACT_EXTENDED = 3'd2,
        ACT_TERM     = 3'd3,
        ACT_STOP     = 3'd4,
        ACT_NO_DEF   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        PS_RUNNING    = 2'd0,
        PS_STOPPED    = 2'd1,
        PS_TERMINATED = 2'd2
    } t_pstate;

    typedef enum logic {
        CFG_PRESENT  = 1'b0,
        CFG_EXTENDED = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_op              op;
        logic             ok;
        logic [SIG_W-1:0] sig;
    } t_cmd;

    typedef struct packed {
        logic             status;
        logic [SIG_W-1:0] delivered_signal;
        t_action          action;
        logic             is_blocked;
        t_pstate          process_state;
        logic             last;
    } t_res;

    function automatic logic [SIG_W-1:0] onehot_index(input logic [SET_W-1:0] v);
        logic [SIG_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SET_W; i++) begin
            if (v[i]) begin
                idx = idx | SIG_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== src/spmd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spmd_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    output logic                   o_full,
    input  wire  [2:0]             i_opcode,
    input  wire  [5:0]             i_signal_number,
    output logic                   o_cmd_valid,
    output spmd_pkg::t_cmd         o_cmd,
    input  wire                    i_cmd_pop
);

    spmd_pkg::t_cmd                     r_q [spmd_pkg::CMDQ_DEPTH];
    logic [spmd_pkg::CMDQ_AW-1:0]       r_wr_ptr;
    logic [spmd_pkg::CMDQ_AW-1:0]       r_rd_ptr;
    logic [spmd_pkg::CMDQ_CW-1:0]       r_count;
    spmd_pkg::t_cmd                     cmd_in;
    logic                               wr_en;
    logic                               rd_en;

    // classify
    always_comb begin
        cmd_in.ok  = (i_signal_number != 6'd0) &&
                     (i_signal_number <= 6'(spmd_pkg::SIG_TOP));
        cmd_in.sig = cmd_in.ok ? i_signal_number[spmd_pkg::SIG_W-1:0] : '0;
        case (i_opcode)
            spmd_pkg::OPC_SEND:    cmd_in.op = spmd_pkg::OP_SEND;
            spmd_pkg::OPC_BLOCK:   cmd_in.op = spmd_pkg::OP_BLOCK;
            spmd_pkg::OPC_UNBLOCK: cmd_in.op = spmd_pkg::OP_UNBLOCK;
            spmd_pkg::OPC_DELIVER: cmd_in.op = spmd_pkg::OP_DELIVER;
            spmd_pkg::OPC_QUERY:   cmd_in.op = spmd_pkg::OP_QUERY;
            default:               cmd_in.op = spmd_pkg::OP_OTHER;
        endcase
    end

    assign o_full      = (r_count == spmd_pkg::CMDQ_CW'(spmd_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/spmd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spmd_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cmd_valid,
    input  spmd_pkg::t_cmd                   i_cmd,
    output logic                             o_cmd_pop,
    input  wire  [spmd_pkg::SET_W-1:0]       i_present_mask,
    input  wire  [spmd_pkg::SET_W-1:0]       i_extended_mask,
    output logic                             o_res_valid,
    output spmd_pkg::t_res                   o_res,
    input  wire                              i_res_pop
);

    logic [spmd_pkg::SET_W-1:0] r_pending;
    logic [spmd_pkg::SET_W-1:0] r_blocked;
    spmd_pkg::t_pstate          r_pstate;
    logic                       r_out_valid;
    spmd_pkg::t_res             r_out;

    logic [spmd_pkg::SET_W-1:0] n_pending;
    logic [spmd_pkg::SET_W-1:0] n_blocked;
    spmd_pkg::t_pstate          n_pstate;
    spmd_pkg::t_res             n_out;

    logic                       advance;
    logic [spmd_pkg::SET_W-1:0] sig_bit;
    logic [spmd_pkg::SET_W-1:0] deliverable;
    logic [spmd_pkg::SET_W-1:0] lowest;
    logic [spmd_pkg::SET_W-1:0] remaining;
    logic [spmd_pkg::SET_W-1:0] present;
    logic [spmd_pkg::SIG_W-1:0] low_idx;

    assign advance     = i_cmd_valid && (!r_out_valid || i_res_pop);
    assign sig_bit     = spmd_pkg::SET_W'(1) << i_cmd.sig;
    assign deliverable = r_pending & ~r_blocked & spmd_pkg::SIG_MASK;
    assign lowest      = deliverable & (~deliverable + 1'b1);
    assign remaining   = deliverable & ~lowest;
    assign low_idx     = spmd_pkg::onehot_index(lowest);
    assign present     = i_present_mask & ~spmd_pkg::HANDLER_IGNORED;

    always_comb begin
        n_pending = r_pending;
        n_blocked = r_blocked;
        n_pstate  = r_pstate;
        o_cmd_pop = advance;
        n_out.status           = 1'b0;
        n_out.delivered_signal = '0;
        n_out.action           = spmd_pkg::ACT_NOTHING;
        n_out.is_blocked       = 1'b0;
        n_out.last             = 1'b1;
        case (i_cmd.op)
            spmd_pkg::OP_SEND: begin
                n_out.status = !i_cmd.ok;
                if (i_cmd.ok) begin
                    if (i_cmd.sig == spmd_pkg::SIG_KILL) begin
                        n_pstate = spmd_pkg::PS_TERMINATED;
                    end else begin
                        n_pending = r_pending | sig_bit;
                    end
                end
            end
            spmd_pkg::OP_BLOCK: begin
                n_out.status = !i_cmd.ok;
                if (i_cmd.ok && i_cmd.sig != spmd_pkg::SIG_KILL) begin
                    n_blocked = r_blocked | sig_bit;
                end
            end
            spmd_pkg::OP_UNBLOCK: begin
                n_out.status = !i_cmd.ok;
                if (i_cmd.ok) begin
                    n_blocked = r_blocked & ~sig_bit;
                end
            end
            spmd_pkg::OP_QUERY: begin
                n_out.status     = !i_cmd.ok;
                n_out.is_blocked = i_cmd.ok && r_blocked[i_cmd.sig];
            end
            spmd_pkg::OP_DELIVER: begin
                if (deliverable != '0) begin
                    // one signal per beat, lowest first
                    n_pending              = r_pending & ~lowest;
                    n_out.delivered_signal = low_idx;
                    n_out.last             = (remaining == '0);
                    o_cmd_pop              = advance && (remaining == '0);
                    if ((present & lowest) != '0) begin
                        n_out.action = ((i_extended_mask & lowest) != '0) ?
                                       spmd_pkg::ACT_EXTENDED : spmd_pkg::ACT_BASIC;
                    end else if ((spmd_pkg::TERM_DEFAULT_MASK & lowest) != '0) begin
                        n_out.action = spmd_pkg::ACT_TERM;
                        n_pstate     = spmd_pkg::PS_TERMINATED;
                    end else if ((spmd_pkg::STOP_DEFAULT_MASK & lowest) != '0) begin
                        n_out.action = spmd_pkg::ACT_STOP;
                        if (r_pstate != spmd_pkg::PS_TERMINATED) begin
                            n_pstate = spmd_pkg::PS_STOPPED;
                        end
                    end else begin
                        n_out.action = spmd_pkg::ACT_NO_DEF;
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.process_state = n_pstate;
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_blocked   <= '0;
            r_pstate    <= spmd_pkg::PS_RUNNING;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_pending   <= n_pending;
                r_blocked   <= n_blocked;
                r_pstate    <= n_pstate;
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_term_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pstate == spmd_pkg::PS_TERMINATED |=> r_pstate == spmd_pkg::PS_TERMINATED)
        else $error("terminated state left");

    a_pop_needs_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> advance)
        else $error("command popped without a result beat");

    a_deliver_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && i_cmd.op == spmd_pkg::OP_DELIVER && deliverable != '0
        |=> (r_pending & $past(lowest)) == '0)
        else $error("delivered signal still pending");

    a_state_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.process_state == r_pstate)
        else $error("result state out of step");

endmodule

`default_nettype wire

// ===== src/signal_pending_mask_dispatcher.sv =====
// Signal pending/blocked mask dispatcher. Items go in through push/full and results come out
// through empty/pop, both queue-style. A two-entry command queue decouples intake from the
// execution unit, which produces one result beat per cycle into an output register when it
// is free or popped: send, block, unblock, query and unknown opcodes give one result each, a
// deliver gives one result per deliverable signal (at least one), lowest signal first, with
// last set on the final one. An item passes the command queue, then the output register; a
// deliver stays queued until its last signal. The user must write the handler masks over the
// APB port (present at 0x0, extended at 0x4) while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module signal_pending_mask_dispatcher (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire  [2:0]                   i_opcode,
    input  wire  [5:0]                   i_signal_number,
    output logic                         empty,
    input  wire                          pop,
    output logic                         o_status,
    output logic [4:0]                   o_delivered_signal,
    output logic [2:0]                   o_action,
    output logic                         o_is_blocked,
    output logic [1:0]                   o_process_state,
    output logic                         o_last,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [spmd_pkg::CFG_AW-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [spmd_pkg::SET_W-1:0] r_present_mask;
    logic [spmd_pkg::SET_W-1:0] r_extended_mask;
    logic                       cfg_wr;
    spmd_pkg::t_cfg_reg         cfg_sel;

    logic                       cmd_valid;
    spmd_pkg::t_cmd             cmd;
    logic                       cmd_pop;
    logic                       res_valid;
    spmd_pkg::t_res             res;

    assign pready  = 1'b1;
    assign cfg_sel = spmd_pkg::t_cfg_reg'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present_mask  <= '0;
            r_extended_mask <= '0;
        end else if (cfg_wr) begin
            case (cfg_sel)
                spmd_pkg::CFG_PRESENT:  r_present_mask  <= pwdata;
                spmd_pkg::CFG_EXTENDED: r_extended_mask <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            spmd_pkg::CFG_PRESENT:  prdata = r_present_mask;
            spmd_pkg::CFG_EXTENDED: prdata = r_extended_mask;
            default:                prdata = '0;
        endcase
    end

    spmd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_opcode        (i_opcode),
        .i_signal_number (i_signal_number),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    spmd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .i_present_mask  (r_present_mask),
        .i_extended_mask (r_extended_mask),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .i_res_pop       (pop)
    );

    assign empty              = !res_valid;
    assign o_status           = res.status;
    assign o_delivered_signal = res.delivered_signal;
    assign o_action           = res.action;
    assign o_is_blocked       = res.is_blocked;
    assign o_process_state    = res.process_state;
    assign o_last             = res.last;

endmodule

`default_nettype wire
